/* rtl/core/calendar_date_counter_top_macros.svh */
// ----------------------------------------------------------------------------
// Calendar date counter assertion macros
// Shared property forms for the checker; clock is clk, reset is rst_n.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_COUNTER_TOP_MACROS_SVH
`define CALENDAR_DATE_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define CAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define CAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset
`define CAL_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cal_pkg.sv */
// ----------------------------------------------------------------------------
// Calendar date counter package
// Word types, state struct, request and field codes, calendar constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

  // Widths
  localparam int unsigned MS_W    = 27;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned YMOD_W  = 9;
  localparam int unsigned STEP_W  = 10;

  // Request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADJUST = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // Adjust field codes
  localparam logic [1:0] FIELD_DAY   = 2'd0;
  localparam logic [1:0] FIELD_MONTH = 2'd1;
  localparam logic [1:0] FIELD_YEAR  = 2'd2;
  localparam logic [1:0] FIELD_NONE  = 2'd3;  // not a date field

  // Adjust direction
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  // Status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_FIELD = 1'b1;

  // Calendar constants
  localparam logic [MS_W-1:0]    MS_PER_DAY  = 27'd86400000;
  localparam logic [DAY_W-1:0]   DAY_MIN     = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_MAX     = 5'd31;
  localparam logic [MONTH_W-1:0] MONTH_MIN   = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX   = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [YMOD_W-1:0]  YMOD_LAST   = 9'd399;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 10'd1;

  // Input word
  typedef struct packed {
    logic [1:0] req_type;
    logic       direction;
    logic [1:0] field_select;
  } cal_in_t;

  // Result word
  typedef struct packed {
    logic [DAY_W-1:0]   day_out;
    logic [MONTH_W-1:0] month_out;
    logic [YEAR_W-1:0]  year_out;
    logic               status;
  } cal_out_t;

  // Counter and date state; ymod tracks year mod 400 for the leap test
  typedef struct packed {
    logic [MS_W-1:0]    ms_count;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [YMOD_W-1:0]  ymod;
  } cal_state_t;

endpackage

`default_nettype wire

/* rtl/core/calendar_date_counter_top.sv */
// ----------------------------------------------------------------------------
// Calendar date counter top level
// Millisecond day counter with Gregorian date, APB step register.
// ----------------------------------------------------------------------------
// One result per request word, in the cycle after acceptance. A new word is
// taken every cycle while the output register is empty or being drained, so
// the sustained rate is one word per clock; the date and counter registers
// update at acceptance, so back-to-back words see each other's effect. The
// tick step lives at byte address 0 (reset 1 ms). Leap years come from a
// year-mod-400 register kept alongside the year. Reset date is set by the
// RST_DAY, RST_MONTH and RST_YEAR parameters.
`default_nettype none

module calendar_date_counter_top
  import cal_pkg::*;
#(
  parameter int unsigned RST_DAY   = 1,
  parameter int unsigned RST_MONTH = 1,
  parameter int unsigned RST_YEAR  = 2000
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  cal_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output cal_out_t    out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [YMOD_W-1:0] RST_YMOD = YMOD_W'(RST_YEAR % 400);

  cal_state_t          state_r, state_nxt;
  cal_out_t            out_data_r, result_nxt;
  logic                out_valid_r;
  logic [STEP_W-1:0]   tick_step_r;
  logic                in_accept;
  logic                cfg_write;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? {{(32-STEP_W){1'b0}}, tick_step_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r <= STEP_RESET;
    end else if (cfg_write) begin
      tick_step_r <= pwdata[STEP_W-1:0];
    end
  end

  // Handshake: output register frees as it drains
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  cal_date_step u_step (
    .state_i     (state_r),
    .req_i       (in_data),
    .tick_step_i (tick_step_r),
    .state_o     (state_nxt),
    .result_o    (result_nxt)
  );

  // Date state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.ms_count <= '0;
      state_r.day      <= DAY_W'(RST_DAY);
      state_r.month    <= MONTH_W'(RST_MONTH);
      state_r.year     <= YEAR_W'(RST_YEAR);
      state_r.ymod     <= RST_YMOD;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/core/cal_date_step.sv */
// ----------------------------------------------------------------------------
// Calendar date step
// Next-state logic for one word: tick with day rollover, field adjust, read.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_date_step
  import cal_pkg::*;
(
  input  cal_state_t              state_i,
  input  cal_in_t                 req_i,
  input  logic [STEP_W-1:0]       tick_step_i,
  output cal_state_t              state_o,
  output cal_out_t                result_o
);

  logic [MS_W:0]      ms_sum;
  logic               day_end;
  logic               leap;
  logic [DAY_W-1:0]   month_len;
  logic [DAY_W:0]     day_inc;
  logic [YMOD_W-1:0]  ymod_inc;
  logic [YMOD_W-1:0]  ymod_dec;
  logic               status;

  // Leap test from year mod 400: multiple of 4, not 100/200/300
  assign leap = (state_i.ymod[1:0] == 2'd0) &&
                (state_i.ymod != 9'd100) &&
                (state_i.ymod != 9'd200) &&
                (state_i.ymod != 9'd300);

  // Days in current month
  always_comb begin
    case (state_i.month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd2:    month_len = leap ? 5'd29 : 5'd28;
      default: month_len = 5'd30;
    endcase
  end

  assign ms_sum   = {1'b0, state_i.ms_count} + {{(MS_W+1-STEP_W){1'b0}}, tick_step_i};
  assign day_end  = (ms_sum >= {1'b0, MS_PER_DAY});
  assign day_inc  = {1'b0, state_i.day} + {{DAY_W{1'b0}}, 1'b1};
  assign ymod_inc = (state_i.ymod >= YMOD_LAST) ? '0 : state_i.ymod + 9'd1;
  assign ymod_dec = (state_i.ymod == '0) ? YMOD_LAST : state_i.ymod - 9'd1;

  // Next state
  always_comb begin
    state_o = state_i;
    status  = STATUS_OK;
    case (req_i.req_type)
      REQ_TICK: begin
        state_o.ms_count = ms_sum[MS_W-1:0];
        if (day_end) begin
          state_o.ms_count = '0;
          if (day_inc > {1'b0, month_len}) begin
            state_o.day = DAY_MIN;
            if (state_i.month >= MONTH_MAX) begin
              state_o.month = MONTH_MIN;
              if (state_i.year >= YEAR_MAX) begin
                state_o.year = '0;
                state_o.ymod = '0;
              end else begin
                state_o.year = state_i.year + 14'd1;
                state_o.ymod = ymod_inc;
              end
            end else begin
              state_o.month = state_i.month + 4'd1;
            end
          end else begin
            state_o.day = day_inc[DAY_W-1:0];
          end
        end
      end
      REQ_ADJUST: begin
        case (req_i.field_select)
          FIELD_DAY: begin
            if (req_i.direction == DIR_DOWN) begin
              state_o.day = (state_i.day > DAY_MIN) ? state_i.day - 5'd1 : DAY_MIN;
            end else begin
              state_o.day = (state_i.day < DAY_MAX) ? state_i.day + 5'd1 : DAY_MAX;
            end
          end
          FIELD_MONTH: begin
            if (req_i.direction == DIR_DOWN) begin
              state_o.month = (state_i.month > MONTH_MIN) ? state_i.month - 4'd1
                                                          : MONTH_MIN;
            end else begin
              state_o.month = (state_i.month < MONTH_MAX) ? state_i.month + 4'd1
                                                          : MONTH_MAX;
            end
          end
          FIELD_YEAR: begin
            if (req_i.direction == DIR_DOWN) begin
              if (state_i.year > '0) begin
                state_o.year = state_i.year - 14'd1;
                state_o.ymod = ymod_dec;
              end
            end else begin
              if (state_i.year < YEAR_MAX) begin
                state_o.year = state_i.year + 14'd1;
                state_o.ymod = ymod_inc;
              end
            end
          end
          default: status = STATUS_BAD_FIELD;
        endcase
      end
      default: ;  // read, and the unused code, leave state alone
    endcase
  end

  // Result word reflects the date after this request
  assign result_o.day_out   = state_o.day;
  assign result_o.month_out = state_o.month;
  assign result_o.year_out  = state_o.year;
  assign result_o.status    = status;

endmodule

`default_nettype wire

/* rtl/core/cal_checker.sv */
// ----------------------------------------------------------------------------
// Calendar date counter checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_date_counter_top_macros.svh"

module cal_checker
  import cal_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire cal_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire cal_out_t out_data
);

  logic in_take;
  logic out_stall;
  logic bad_adjust;

  assign in_take    = in_valid && in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign bad_adjust = (in_data.req_type == REQ_ADJUST) &&
                      (in_data.field_select == FIELD_NONE);

  // Result word held while stalled
  `CAL_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result word moved")

  // Accepted request shows a result on the next cycle
  `CAL_ASSERT_NEXT(a_one_latency, in_take, out_valid, "no result after accepted word")

  // Empty output register never blocks input
  `CAL_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

  // Status set only on an adjust with the invalid field code
  `CAL_ASSERT_NEXT(a_status_src, in_take && !bad_adjust, out_data.status == STATUS_OK, "bad status")

  // No result straight out of reset
  `CAL_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

endmodule

bind calendar_date_counter_top cal_checker u_cal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
